// ===== hdl/vpa_pkg.sv =====
// Shared types and constants for the voice pair allocator.
// Used by the channel interfaces and the top level.
package vpa_pkg;

   localparam int NUM_VOICES_DEFAULT = 64;

   localparam int VOICE_W = 6;
   localparam int FLAGS_W = 3;
   localparam int USAGE_W = 2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam int FLAG_MONO_BIT = 0;

   localparam logic [1:0] ROLE_NONE   = 2'b00;
   localparam logic [1:0] ROLE_MASTER = 2'b01;
   localparam logic [1:0] ROLE_SLAVE  = 2'b10;

   // One voice table entry. The five flag bits are {role, request flags}.
   typedef struct packed {
      logic               link;
      logic [1:0]         role;
      logic [FLAGS_W-1:0] rflags;
      logic [USAGE_W-1:0] usage;
   } voice_word_type;

   localparam int WORD_W = $bits(voice_word_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WR_LO,
      ST_WR_HI,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FREE_HI,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/vpa_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on vpa_pkg for the field widths.
interface vpa_req_if;
   import vpa_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [FLAGS_W-1:0] request_flags;
   logic [USAGE_W-1:0] usage_code;
   logic [VOICE_W-1:0] voice_index;

   modport source (output valid, output req_type, output request_flags,
                   output usage_code, output voice_index, input ready);
   modport sink   (input valid, input req_type, input request_flags,
                   input usage_code, input voice_index, output ready);
endinterface

interface vpa_rsp_if;
   import vpa_pkg::*;
   logic               valid;
   logic               ready;
   logic               granted;
   logic [VOICE_W-1:0] chosen_voice;
   logic               is_pair;

   modport source (output valid, output granted, output chosen_voice,
                   output is_pair, input ready);
   modport sink   (input valid, input granted, input chosen_voice,
                   input is_pair, output ready);
endinterface

// ===== hdl/vpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/voice_pair_allocator_unit.sv =====
// Voice pair allocator top level: voice table in a RAM, scanned by a small sequencer.
// Allocate: voices are scanned in order up to the hit (at most NUM_VOICES), then one word
// is written (mono) or two (pair), then the result goes into the response register.
// Free: read and clear the entry and a linked partner; out of range, just the response.
// One item at a time; the scan through the single RAM read port sets the rate.
// Reset clears the per-voice valid bits, so the whole table reads as free at once.
module voice_pair_allocator_unit #(
   parameter int NUM_VOICES = vpa_pkg::NUM_VOICES_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   vpa_req_if.sink  req_port,
   vpa_rsp_if.source rsp_port
);
   import vpa_pkg::*;

   localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CW = $clog2(NUM_VOICES + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IW-1:0]      chk_idx_ff, chk_idx_in;
   logic               even_free_ff, even_free_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [NUM_VOICES-1:0] vbit_ff, vbit_in;
   logic [IW-1:0]      tgt_ff, tgt_in;
   logic               pair_ff, pair_in;
   voice_word_type     lo_word_ff, lo_word_in;
   voice_word_type     hi_word_ff, hi_word_in;
   logic [FLAGS_W-1:0] rflags_ff, rflags_in;
   logic [USAGE_W-1:0] usage_ff, usage_in;
   logic               res_granted_ff, res_granted_in;
   logic [VOICE_W-1:0] res_voice_ff, res_voice_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [VOICE_W-1:0] rsp_voice_ff, rsp_voice_in;
   logic               rsp_pair_ff, rsp_pair_in;

   logic               accept;
   logic               issue;
   logic               mono;
   logic               free_now;
   logic               hit;
   logic               scan_end;
   logic               free_link;
   logic               slot_free;
   logic [IW-1:0]      hit_idx;
   logic [IW-1:0]      rd_addr;
   logic [WORD_W-1:0]  rd_data;
   voice_word_type     rd_word;
   logic               mem_we;
   logic [IW-1:0]      wr_addr;
   voice_word_type     wr_word;

   vpa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_VOICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // An entry never written since reset reads as a free, unlinked voice.
   assign rd_word   = rd_vld_ff ? voice_word_type'(rd_data) : '0;
   assign accept    = req_port.valid && req_port.ready;
   assign issue     = (state_ff == ST_SCAN) && (cnt_ff < CW'(NUM_VOICES));
   assign mono      = rflags_ff[FLAG_MONO_BIT];
   assign free_now  = (rd_word.usage == '0);
   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   // A pair hits on the odd voice when its even neighbour was seen free just before.
   assign hit = (state_ff == ST_SCAN) && chk_vld_ff && free_now &&
                (mono || (chk_idx_ff[0] && even_free_ff));
   assign hit_idx  = mono ? chk_idx_ff : (chk_idx_ff & ~IW'(1));
   assign scan_end = (state_ff == ST_SCAN) && chk_vld_ff &&
                     (chk_idx_ff == IW'(NUM_VOICES - 1)) && !hit;
   assign free_link = rd_word.link && ((int'(tgt_ff) + 1) < NUM_VOICES);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_port.req_type == REQ_FREE) begin
                  state_in = (int'(req_port.voice_index) < NUM_VOICES) ? ST_FREE_RD : ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_WR_LO;
            end else if (scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_WR_LO:    state_in = pair_ff ? ST_WR_HI : ST_RESP;
         ST_WR_HI:    state_in = ST_RESP;
         ST_FREE_RD:  state_in = ST_FREE_CHK;
         ST_FREE_CHK: state_in = free_link ? ST_FREE_HI : ST_RESP;
         ST_FREE_HI:  state_in = ST_RESP;
         ST_RESP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, RAM read and write controls.
   always_comb begin
      req_port.ready = 1'b0;
      rd_addr        = cnt_ff[IW-1:0];
      mem_we         = 1'b0;
      wr_addr        = tgt_ff;
      wr_word        = '0;
      case (state_ff)
         ST_IDLE:     req_port.ready = 1'b1;
         ST_FREE_RD:  rd_addr = tgt_ff;
         ST_WR_LO: begin
            mem_we  = 1'b1;
            wr_word = lo_word_ff;
         end
         ST_WR_HI: begin
            mem_we  = 1'b1;
            wr_addr = tgt_ff + IW'(1);
            wr_word = hi_word_ff;
         end
         ST_FREE_CHK: mem_we = 1'b1;
         ST_FREE_HI: begin
            mem_we  = 1'b1;
            wr_addr = tgt_ff + IW'(1);
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cnt_in         = cnt_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = cnt_ff[IW-1:0];
      even_free_in   = even_free_ff;
      rd_vld_in      = 1'b0;
      vbit_in        = vbit_ff;
      tgt_in         = tgt_ff;
      pair_in        = pair_ff;
      lo_word_in     = lo_word_ff;
      hi_word_in     = hi_word_ff;
      rflags_in      = rflags_ff;
      usage_in       = usage_ff;
      res_granted_in = res_granted_ff;
      res_voice_in   = res_voice_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_voice_in   = rsp_voice_ff;
      rsp_pair_in    = rsp_pair_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;

      if (mem_we) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            if (wr_addr == IW'(i)) begin
               vbit_in[i] = 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rflags_in      = req_port.request_flags;
               usage_in       = req_port.usage_code;
               cnt_in         = '0;
               even_free_in   = 1'b0;
               pair_in        = 1'b0;
               res_granted_in = 1'b0;
               res_voice_in   = '0;
               tgt_in         = IW'(req_port.voice_index);
               if (req_port.req_type == REQ_FREE) begin
                  res_voice_in = req_port.voice_index;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in    = cnt_ff + CW'(1);
               rd_vld_in = vbit_ff[rd_addr];
            end
            chk_vld_in = issue && !hit;
            if (chk_vld_ff && !chk_idx_ff[0]) begin
               even_free_in = free_now;
            end
            if (hit) begin
               tgt_in         = hit_idx;
               pair_in        = !mono;
               res_granted_in = 1'b1;
               res_voice_in   = VOICE_W'(hit_idx);
               lo_word_in     = '{link: mono ? rd_word.link : 1'b1, role: ROLE_MASTER,
                                  rflags: rflags_ff, usage: usage_ff};
               hi_word_in     = '{link: rd_word.link, role: ROLE_SLAVE,
                                  rflags: rflags_ff, usage: usage_ff};
            end
         end
         ST_FREE_RD: rd_vld_in = vbit_ff[rd_addr];
         ST_FREE_CHK: begin
            res_granted_in = 1'b1;
            pair_in        = free_link;
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_voice_in   = res_voice_ff;
               rsp_pair_in    = pair_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         vbit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rd_vld_ff    <= rd_vld_in;
         vbit_ff      <= vbit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      even_free_ff   <= even_free_in;
      tgt_ff         <= tgt_in;
      pair_ff        <= pair_in;
      lo_word_ff     <= lo_word_in;
      hi_word_ff     <= hi_word_in;
      rflags_ff      <= rflags_in;
      usage_ff       <= usage_in;
      res_granted_ff <= res_granted_in;
      res_voice_ff   <= res_voice_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_voice_ff   <= rsp_voice_in;
      rsp_pair_ff    <= rsp_pair_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.granted      = rsp_granted_ff;
   assign rsp_port.chosen_voice = rsp_voice_ff;
   assign rsp_port.is_pair      = rsp_pair_ff;

endmodule
